// File: rtl/pmid_pkg.sv
package pmid_pkg;

  localparam int CW = 32;
  localparam int MW = CW + 1;
  localparam int LW = 31;
  localparam int SQW = 2 * MW;
  localparam int SW = SQW + 2;
  localparam int NUM_AXES = 3;
  localparam int LANE_LAT = MW + 4;
  localparam int SQRT_LAT = MW + 1;
  localparam int PIPE_LAT = LANE_LAT + SQRT_LAT;
  localparam int LOW_W = 16;
  localparam int HIGH_W = MW - LOW_W;

  localparam logic [2:0] REG_BOX_X = 3'd0;
  localparam logic [2:0] REG_BOX_Y = 3'd1;
  localparam logic [2:0] REG_BOX_Z = 3'd2;
  localparam logic [2:0] REG_PERIODIC_DIMS = 3'd3;

  localparam logic [LW-1:0] BOX_RESET = LW'(65536);
  localparam logic [1:0] DIMS_RESET = 2'd3;

endpackage

// File: rtl/pmid_lane.sv
module pmid_lane
  import pmid_pkg::*;
(
  input  logic                  clk,
  input  logic                  adv,
  input  logic signed [CW-1:0]  a,
  input  logic signed [CW-1:0]  b,
  input  logic [LW-1:0]         len,
  input  logic                  per,
  output logic [SQW-1:0]        sq
);

  logic [MW-1:0] d;
  logic [MW-1:0] mag;
  logic [MW-1:0] mag_p [MW+1];
  logic [LW-1:0] len_p [MW+1];
  logic          per_p [MW+1];
  logic [LW-1:0] rem_p [MW+1];
  logic [LW-1:0] rem_nx [MW];
  logic [MW-1:0] m;
  logic [MW-1:0] m_next;
  logic [2*HIGH_W-1:0] hh;
  logic [HIGH_W+LOW_W-1:0] hl;
  logic [2*LOW_W-1:0] ll;

  assign d = {a[CW-1], a} - {b[CW-1], b};
  assign mag = d[MW-1] ? (~d + MW'(1)) : d;

  for (genvar k = 0; k < MW; k++) begin : g_rem
    logic [LW:0] t;
    assign t = {rem_p[k], mag_p[k][MW-1-k]};
    assign rem_nx[k] = (t >= {1'b0, len_p[k]}) ? LW'(t - {1'b0, len_p[k]}) : t[LW-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_p[0] <= mag;
      len_p[0] <= len;
      per_p[0] <= per;
      rem_p[0] <= '0;
      for (int k = 0; k < MW; k++) begin
        mag_p[k+1] <= mag_p[k];
        len_p[k+1] <= len_p[k];
        per_p[k+1] <= per_p[k];
        rem_p[k+1] <= rem_nx[k];
      end
    end
  end

  always_comb begin
    if (!per_p[MW]) begin
      m_next = mag_p[MW];
    end else if ({rem_p[MW], 1'b0} >= {1'b0, len_p[MW]}) begin
      m_next = MW'(len_p[MW] - rem_p[MW]);
    end else begin
      m_next = MW'(rem_p[MW]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m  <= m_next;
      hh <= {{HIGH_W{1'b0}}, m[MW-1:LOW_W]} * {{HIGH_W{1'b0}}, m[MW-1:LOW_W]};
      hl <= {{LOW_W{1'b0}}, m[MW-1:LOW_W]} * {{HIGH_W{1'b0}}, m[LOW_W-1:0]};
      ll <= {{LOW_W{1'b0}}, m[LOW_W-1:0]} * {{LOW_W{1'b0}}, m[LOW_W-1:0]};
      sq <= (SQW'(hh) << (2 * LOW_W)) + (SQW'(hl) << (LOW_W + 1)) + SQW'(ll);
    end
  end

endmodule

// File: rtl/pmid_sqrt.sv
module pmid_sqrt
  import pmid_pkg::*;
(
  input  logic            clk,
  input  logic            adv,
  input  logic [SQW-1:0]  sq_x,
  input  logic [SQW-1:0]  sq_y,
  input  logic [SQW-1:0]  sq_z,
  output logic [MW-1:0]   root
);

  logic [SW-1:0] total;
  logic [SW-1:0] rem_p [MW+1];
  logic [MW-1:0] q_p [MW+1];
  logic          sat_p [MW+1];
  logic [SW-1:0] rem_nx [MW];
  logic [MW-1:0] q_nx [MW];

  assign total = SW'(sq_x) + SW'(sq_y) + SW'(sq_z);

  for (genvar k = 0; k < MW; k++) begin : g_bit
    localparam int B = MW - 1 - k;
    logic [SW-1:0] trial;
    logic          take;
    assign trial = (SW'(q_p[k]) << (B + 1)) | (SW'(1) << (2 * B));
    assign take = rem_p[k] >= trial;
    assign rem_nx[k] = take ? rem_p[k] - trial : rem_p[k];
    assign q_nx[k] = take ? (q_p[k] | (MW'(1) << B)) : q_p[k];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_p[0] <= total;
      q_p[0]   <= '0;
      sat_p[0] <= |total[SW-1:SQW];
      for (int k = 0; k < MW; k++) begin
        rem_p[k+1] <= rem_nx[k];
        q_p[k+1]   <= q_nx[k];
        sat_p[k+1] <= sat_p[k];
      end
    end
  end

  assign root = sat_p[MW] ? '1 : q_p[MW];

endmodule

// File: rtl/periodic_min_image_distance_top.sv
// An accepted pair passes the per-axis lanes, then the square root.
// Throughput: one pair per cycle while the output is not stalled;
// per-axis remainder and square root each resolve one bit per pipeline
// stage, which sets the depth. The whole pipeline holds while a shown
// result is stalled. Reset clears all valid flags and loads box lengths
// of 1.0 and three periodic axes.
module periodic_min_image_distance_top
  import pmid_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pair_valid,
  output logic                 pair_stall,
  input  logic signed [CW-1:0] first_x,
  input  logic signed [CW-1:0] first_y,
  input  logic signed [CW-1:0] first_z,
  input  logic signed [CW-1:0] second_x,
  input  logic signed [CW-1:0] second_y,
  input  logic signed [CW-1:0] second_z,
  output logic                 dist_valid,
  input  logic                 dist_stall,
  output logic [MW-1:0]        distance,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [LW-1:0]        cfg_data
);

  logic [LW-1:0] box_x;
  logic [LW-1:0] box_y;
  logic [LW-1:0] box_z;
  logic [1:0]    periodic_dims;
  logic [PIPE_LAT-1:0] vld;
  logic adv;
  logic per_x;
  logic per_y;
  logic per_z;
  logic [SQW-1:0] sq_x;
  logic [SQW-1:0] sq_y;
  logic [SQW-1:0] sq_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_x <= BOX_RESET;
      box_y <= BOX_RESET;
      box_z <= BOX_RESET;
      periodic_dims <= DIMS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BOX_X: box_x <= cfg_data;
        REG_BOX_Y: box_y <= cfg_data;
        REG_BOX_Z: box_z <= cfg_data;
        REG_PERIODIC_DIMS: periodic_dims <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign adv = !vld[PIPE_LAT-1] || !dist_stall;
  assign pair_stall = !adv;
  assign dist_valid = vld[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_LAT-2:0], pair_valid};
    end
  end

  assign per_x = (periodic_dims > 2'd0) && (box_x != '0);
  assign per_y = (periodic_dims > 2'd1) && (box_y != '0);
  assign per_z = (periodic_dims > 2'd2) && (box_z != '0);

  pmid_lane u_lane_x (
    .clk(clk), .adv(adv), .a(first_x), .b(second_x), .len(box_x), .per(per_x), .sq(sq_x)
  );
  pmid_lane u_lane_y (
    .clk(clk), .adv(adv), .a(first_y), .b(second_y), .len(box_y), .per(per_y), .sq(sq_y)
  );
  pmid_lane u_lane_z (
    .clk(clk), .adv(adv), .a(first_z), .b(second_z), .len(box_z), .per(per_z), .sq(sq_z)
  );

  pmid_sqrt u_sqrt (
    .clk(clk), .adv(adv), .sq_x(sq_x), .sq_y(sq_y), .sq_z(sq_z), .root(distance)
  );

endmodule

// File: rtl/pmid_checker.sv
module pmid_checker
  import pmid_pkg::*;
(
  input logic          clk,
  input logic          rst,
  input logic          pair_stall,
  input logic          dist_valid,
  input logic          dist_stall,
  input logic [MW-1:0] distance
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    dist_valid && dist_stall |=> dist_valid && $stable(distance))
    else $error("stalled transaction changed");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    pair_stall == (dist_valid && dist_stall))
    else $error("input stall does not follow output stall");

  a_reset: assert property (@(posedge clk) rst |=> !dist_valid)
    else $error("output valid right after reset");

  a_no_early: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |=> !dist_valid)
    else $error("result too soon after reset");

endmodule

bind periodic_min_image_distance_top pmid_checker u_pmid_checker (
  .clk(clk), .rst(rst), .pair_stall(pair_stall),
  .dist_valid(dist_valid), .dist_stall(dist_stall), .distance(distance)
);
